FILE: design/sitda_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and decimal weight functions for the decimal text converter.
package sitda_pkg;

  localparam int unsigned CHAR_W = 6;
  localparam int unsigned CALC_W = 68;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SIGN  = 3'b010,
    ST_DIGIT = 3'b100
  } state_e;

  // Number of decimal digits needed for the largest magnitude, 2^(w-1).
  function automatic int unsigned num_digits(input int unsigned w);
    logic [CALC_W-1:0] lim;
    logic [CALC_W-1:0] p;
    int unsigned       n;
    lim = CALC_W'(1) << (w - 1);
    p   = CALC_W'(1);
    n   = 0;
    for (int i = 0; i < 20; i++) begin
      if (p <= lim) begin
        n++;
      end
      p = p * CALC_W'(10);
    end
    return n;
  endfunction

  // Weight m * 10^k, used only with constant arguments.
  function automatic logic [CALC_W-1:0] weight(input int unsigned k, input int unsigned m);
    logic [CALC_W-1:0] p;
    p = CALC_W'(m);
    for (int i = 0; i < 20; i++) begin
      if (i < k) begin
        p = p * CALC_W'(10);
      end
    end
    return p;
  endfunction

endpackage

FILE: design/sitda_fifo.sv
`timescale 1ns / 1ps
// Small register queue with push/full and pop/empty sides.
module sitda_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  // DEPTH must be a power of two so that the pointers wrap on their own.
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d  = do_push ? wptr_q + PTR_W'(1) : wptr_q;
    rptr_d  = do_pop ? rptr_q + PTR_W'(1) : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: design/sitda_front.sv
`timescale 1ns / 1ps
// Front end: accepts an integer and splits it into sign and unsigned magnitude.
module sitda_front #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   push_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   full_o,
  output logic                   q_push_o,
  output logic [VALUE_WIDTH:0]   q_data_o,
  input  logic                   q_full_i
);

  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;

  // Negating the most negative value wraps to 2^(W-1), which is exactly
  // its magnitude when read as unsigned.
  assign neg      = value_i[VALUE_WIDTH-1];
  assign mag      = neg ? (~value_i + VALUE_WIDTH'(1)) : value_i;
  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;
  assign q_data_o = {neg, mag};

endmodule

FILE: design/sitda_back.sv
`timescale 1ns / 1ps
// Back end: a minus sign if negative, then digits MSB first, one per unstalled cycle.
module sitda_back #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_empty_i,
  input  logic                   in_neg_i,
  input  logic [VALUE_WIDTH-1:0] in_mag_i,
  output logic                   in_pop_o,
  input  logic                   out_full_i,
  output logic                   out_push_o,
  output sitda_pkg::char_t       out_item_o
);

  import sitda_pkg::*;

  localparam int unsigned NDIG = num_digits(VALUE_WIDTH);
  localparam int unsigned KW   = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int unsigned WW   = VALUE_WIDTH + 4;

  state_e                 state_q, state_d;
  logic [KW-1:0]          k_q, k_d;
  logic                   started_q, started_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;

  logic [WW-1:0]          wtab [NDIG][10];
  logic [WW-1:0]          row [10];
  logic [WW-1:0]          rem_ext;
  logic [3:0]             digit;
  logic [VALUE_WIDTH-1:0] rem_next;
  logic                   emit;
  logic                   last_pos;

  for (genvar k = 0; k < NDIG; k++) begin : g_pos
    for (genvar m = 0; m < 10; m++) begin : g_mul
      assign wtab[k][m] = WW'(weight(k, m));
    end
  end

  always_comb begin
    for (int m = 0; m < 10; m++) begin
      row[m] = wtab[k_q][m];
    end
  end

  assign rem_ext = {4'b0000, rem_q};

  // The remainder is below 10^(k+1), so the digit is the largest m with
  // m * 10^k not above it.
  always_comb begin
    digit = 4'd0;
    for (int m = 1; m < 10; m++) begin
      if (rem_ext >= row[m]) begin
        digit = 4'(m);
      end
    end
  end

  assign rem_next = VALUE_WIDTH'(rem_ext - row[digit]);
  assign last_pos = (k_q == '0);
  assign emit     = started_q || (digit != 4'd0) || last_pos;

  always_comb begin
    state_d         = state_q;
    k_d             = k_q;
    started_d       = started_q;
    rem_d           = rem_q;
    in_pop_o        = 1'b0;
    out_push_o      = 1'b0;
    out_item_o.code = CHAR_ZERO + {2'b00, digit};
    out_item_o.last = last_pos;
    unique case (state_q)
      ST_IDLE: begin
        if (!in_empty_i) begin
          in_pop_o  = 1'b1;
          rem_d     = in_mag_i;
          k_d       = KW'(NDIG - 1);
          started_d = 1'b0;
          state_d   = in_neg_i ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        out_item_o.code = CHAR_MINUS;
        out_item_o.last = 1'b0;
        if (!out_full_i) begin
          out_push_o = 1'b1;
          state_d    = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        // Leading zeros pass without a character and without waiting.
        if (!emit || !out_full_i) begin
          out_push_o = emit;
          rem_d      = rem_next;
          started_d  = started_q || emit;
          if (last_pos) begin
            state_d = ST_IDLE;
          end else begin
            k_d = k_q - KW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      started_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

endmodule

FILE: design/signed_int_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// Top level of the signed integer to decimal ASCII text converter.
//
// Input side: drive value_i and raise push; the item is taken at a clock edge
// where push is high and full is low. Up to two numbers wait in a queue
// between the front end and the digit engine, so the sender rarely stalls.
// Output side: while empty is low, char_code_o and last_char_o show the next
// character; raise pop to take it. last_char_o marks the final character of
// one number's text. Negative numbers start with '-', zero gives "0", and the
// most negative value prints its full magnitude.
// Steps: the digit engine takes a number from the input queue in its idle
// state, writes a minus sign for a negative number, and then handles each
// decimal position in turn from the highest position the width allows down to
// the units, which is 10 positions at 32 bits. The first character is written
// into the character queue and shows on the output once that queue holds it;
// each suppressed leading zero takes its own step before the first digit.
// Each position compares the remainder against the nine multiples of its
// power of ten.
// When the receiver stops popping, a two-entry character queue fills, the
// engine holds its place, and the input queue then raises full.
// Reset clears all queues and returns the engine to idle.
module signed_int_to_decimal_ascii_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [5:0]             char_code_o,
  output logic                   last_char_o
);

  import sitda_pkg::*;

  logic                   mid_push;
  logic                   mid_full;
  logic [VALUE_WIDTH:0]   mid_wdata;
  logic [VALUE_WIDTH:0]   mid_rdata;
  logic                   mid_empty;
  logic                   mid_pop;
  logic                   out_push;
  logic                   out_full;
  char_t                  out_item;
  logic [$bits(char_t)-1:0] out_rdata;
  char_t                  head;

  sitda_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .push_i   (push),
    .value_i  (value_i),
    .full_o   (full),
    .q_push_o (mid_push),
    .q_data_o (mid_wdata),
    .q_full_i (mid_full)
  );

  sitda_fifo #(
    .WIDTH(VALUE_WIDTH + 1),
    .DEPTH(2)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .empty_o (mid_empty)
  );

  sitda_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_empty_i (mid_empty),
    .in_neg_i   (mid_rdata[VALUE_WIDTH]),
    .in_mag_i   (mid_rdata[VALUE_WIDTH-1:0]),
    .in_pop_o   (mid_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_item_o (out_item)
  );

  sitda_fifo #(
    .WIDTH($bits(char_t)),
    .DEPTH(2)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_item),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_rdata),
    .empty_o (empty)
  );

  assign head        = char_t'(out_rdata);
  assign char_code_o = head.code;
  assign last_char_o = head.last;

  // A minus sign always has digits after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && char_code_o == CHAR_MINUS) |-> !last_char_o)
    else $error("minus sign flagged as last character");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (char_code_o == CHAR_MINUS ||
                (char_code_o >= CHAR_ZERO && char_code_o <= CHAR_NINE)))
    else $error("character outside the decimal text set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full)
    else $error("digit engine wrote into a full character queue");

endmodule
